/* hdl/cnps_pkg.sv */
`timescale 1ns / 1ps
package cnps_pkg;

  localparam int PALETTE_ENTRIES_DEF = 1024;
  localparam int GRAIN_EDGE_DEF      = 128;
  localparam int DECAY_DEPTH         = 1024;
  localparam int DECAY_AW            = 10;
  localparam int IDX_MAX             = 1023;
  localparam int WEIGHT_Q16          = 36045;
  localparam int PAL_SPAN            = 5200;
  localparam int V_ONE               = 65536;
  localparam int DECAY_K_FINE        = 26;
  localparam int DECAY_K_COARSE      = 34;
  localparam logic [31:0] GRAIN_SEED = 32'h9E3779B9;
  localparam int GRAIN_BASE          = 150;
  localparam int GRAIN_MASK          = 105;
  localparam int QUEUE_DEPTH         = 4;

  // Per-step decay factors exp(-k/511) in Q0.30 for k = 26 and k = 34, taken
  // from the ten-term series with truncating divisions at every term.
  localparam logic [29:0] DECAY_B_FINE   = 30'd1020475763;
  localparam logic [29:0] DECAY_B_COARSE = 30'd1004624035;

  typedef enum logic [2:0] {
    CFG_TINT_RED     = 3'd0,
    CFG_TINT_GREEN   = 3'd1,
    CFG_TINT_BLUE    = 3'd2,
    CFG_COLOR_OFFSET = 3'd3,
    CFG_DIAG_SCALE   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FS_FILL,
    FS_RUN
  } fill_state_t;

  // One word as it waits in the queue between the front and the back.
  typedef struct packed {
    logic               kind;
    logic               pal_we;
    logic [11:0]        x;
    logic [11:0]        y;
    logic signed [15:0] col_a;
    logic signed [15:0] col_b;
    logic signed [15:0] col_c;
    logic signed [15:0] col_d;
    logic signed [15:0] row_a;
    logic signed [15:0] row_b;
    logic signed [15:0] row_c;
    logic signed [15:0] row_d;
    logic [23:0]        pal_color;
  } item_t;

endpackage

/* hdl/chladni_nodal_pixel_shader.sv */
`timescale 1ns / 1ps
// Chladni nodal pixel shader.
// Input channel (in_valid/in_ready): one word per pixel or palette write.
// With kind low the word shades the pixel at (x, y) from its eight Q1.14
// cosines and yields one pixel_color word on the output channel
// (out_valid/out_ready). With kind high it writes palette_color into palette
// entry x and yields nothing; indexes past the palette are dropped.
// Configuration: cfg_write with cfg_index and cfg_data loads tint, palette
// offset or diagonal drift in the same cycle; write only while idle.
// Throughput is one word per cycle while the output does not stall. A word
// goes into a four-deep queue, and the back pipeline pulls from it. The
// nine-stage back pipeline is set by its multipliers and the registered
// table and palette reads. While out_valid is high and the receiver holds
// out_ready low, the output register and the whole back pipeline freeze;
// the queue keeps taking words until it is full.
// After reset, in_ready stays low while the grain tile and both decay tables
// are generated into their memories. Configuration writes are taken during
// this time.
module chladni_nodal_pixel_shader #(
  parameter int PALETTE_ENTRIES = cnps_pkg::PALETTE_ENTRIES_DEF,
  parameter int GRAIN_EDGE      = cnps_pkg::GRAIN_EDGE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [11:0]        x,
  input  logic [11:0]        y,
  input  logic signed [15:0] col_a,
  input  logic signed [15:0] col_b,
  input  logic signed [15:0] col_c,
  input  logic signed [15:0] col_d,
  input  logic signed [15:0] row_a,
  input  logic signed [15:0] row_b,
  input  logic signed [15:0] row_c,
  input  logic signed [15:0] row_d,
  input  logic [23:0]        palette_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        pixel_color,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [26:0]        cfg_data
);

  // The fill sweep covers the larger of the grain tile and the decay tables.
  localparam int GN       = GRAIN_EDGE * GRAIN_EDGE;
  localparam int FILL_LEN = (GN > cnps_pkg::DECAY_DEPTH) ? GN : cnps_pkg::DECAY_DEPTH;
  localparam int FAW      = $clog2(FILL_LEN);

  logic [7:0]  tint_red, tint_green, tint_blue;
  logic [11:0] color_offset;
  logic [26:0] diag_scale;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red     <= '0;
      tint_green   <= '0;
      tint_blue    <= '0;
      color_offset <= '0;
      diag_scale   <= '0;
    end else if (cfg_write) begin
      case (cnps_pkg::cfg_reg_e'(cfg_index))
        cnps_pkg::CFG_TINT_RED:     tint_red     <= cfg_data[7:0];
        cnps_pkg::CFG_TINT_GREEN:   tint_green   <= cfg_data[7:0];
        cnps_pkg::CFG_TINT_BLUE:    tint_blue    <= cfg_data[7:0];
        cnps_pkg::CFG_COLOR_OFFSET: color_offset <= cfg_data[11:0];
        cnps_pkg::CFG_DIAG_SCALE:   diag_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            fill_done, fill_we;
  logic [FAW-1:0]  fill_addr;
  logic [7:0]      fill_grain;
  logic [16:0]     fill_fine, fill_coarse;
  logic            head_valid, pop_req;
  cnps_pkg::item_t head;

  cnps_fill #(.FILL_LEN(FILL_LEN), .FAW(FAW)) u_fill (
    .clk        (clk),
    .rst        (rst),
    .done       (fill_done),
    .wr_en      (fill_we),
    .wr_addr    (fill_addr),
    .grain_val  (fill_grain),
    .fine_val   (fill_fine),
    .coarse_val (fill_coarse)
  );

  cnps_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .clk           (clk),
    .rst           (rst),
    .enable        (fill_done),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .x             (x),
    .y             (y),
    .col_a         (col_a),
    .col_b         (col_b),
    .col_c         (col_c),
    .col_d         (col_d),
    .row_a         (row_a),
    .row_b         (row_b),
    .row_c         (row_c),
    .row_d         (row_d),
    .palette_color (palette_color),
    .head_valid    (head_valid),
    .head          (head),
    .pop_req       (pop_req)
  );

  cnps_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .GRAIN_EDGE      (GRAIN_EDGE),
    .FAW             (FAW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop_req      (pop_req),
    .fill_we      (fill_we),
    .fill_addr    (fill_addr),
    .fill_grain   (fill_grain),
    .fill_fine    (fill_fine),
    .fill_coarse  (fill_coarse),
    .tint_red     (tint_red),
    .tint_green   (tint_green),
    .tint_blue    (tint_blue),
    .color_offset (color_offset),
    .diag_scale   (diag_scale),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_color  (pixel_color)
  );

endmodule

/* hdl/cnps_ram.sv */
`timescale 1ns / 1ps
module cnps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/cnps_fill.sv */
`timescale 1ns / 1ps
module cnps_fill #(
  parameter int FILL_LEN = 16384,
  parameter int FAW      = $clog2(FILL_LEN)
) (
  input  logic           clk,
  input  logic           rst,
  output logic           done,
  output logic           wr_en,
  output logic [FAW-1:0] wr_addr,
  output logic [7:0]     grain_val,
  output logic [16:0]    fine_val,
  output logic [16:0]    coarse_val
);

  localparam logic [29:0] B_FINE   = cnps_pkg::DECAY_B_FINE;
  localparam logic [29:0] B_COARSE = cnps_pkg::DECAY_B_COARSE;
  localparam logic [60:0] HALF30   = 61'(1) << 29;

  cnps_pkg::fill_state_t state, state_next;
  logic [FAW-1:0] cnt;
  logic [31:0]    seed;
  logic [30:0]    pf;
  logic [30:0]    pc;
  logic [31:0]    t1, t2, seed_next;
  logic [60:0]    pf_prod, pc_prod;
  logic [30:0]    pf_next, pc_next;

  // Xorshift step with shifts 13, 17 and 5.
  always_comb begin
    t1        = seed ^ (seed << 13);
    t2        = t1 ^ (t1 >> 17);
    seed_next = t2 ^ (t2 << 5);
    grain_val = 8'(cnps_pkg::GRAIN_BASE) + (seed_next[16:9] & 8'(cnps_pkg::GRAIN_MASK));
    fine_val   = 17'((pf + 31'(1 << 13)) >> 14);
    coarse_val = 17'((pc + 31'(1 << 13)) >> 14);
    pf_prod = 61'(pf) * 61'(B_FINE) + HALF30;
    pc_prod = 61'(pc) * 61'(B_COARSE) + HALF30;
    pf_next = pf_prod[60:30];
    pc_next = pc_prod[60:30];
  end

  always_comb begin
    state_next = state;
    case (state)
      cnps_pkg::FS_FILL: begin
        if (cnt == FAW'(FILL_LEN - 1)) begin
          state_next = cnps_pkg::FS_RUN;
        end
      end
      cnps_pkg::FS_RUN: state_next = cnps_pkg::FS_RUN;
      default: state_next = cnps_pkg::FS_FILL;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    done  = 1'b0;
    case (state)
      cnps_pkg::FS_FILL: wr_en = 1'b1;
      cnps_pkg::FS_RUN:  done  = 1'b1;
      default: begin
        wr_en = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  assign wr_addr = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnps_pkg::FS_FILL;
      cnt   <= '0;
      seed  <= cnps_pkg::GRAIN_SEED;
      pf    <= 31'(1) << 30;
      pc    <= 31'(1) << 30;
    end else begin
      state <= state_next;
      if (wr_en) begin
        cnt  <= cnt + FAW'(1);
        seed <= seed_next;
        pf   <= pf_next;
        pc   <= pc_next;
      end
    end
  end

endmodule

/* hdl/cnps_front.sv */
`timescale 1ns / 1ps
module cnps_front #(
  parameter int PALETTE_ENTRIES = cnps_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [11:0]        x,
  input  logic [11:0]        y,
  input  logic signed [15:0] col_a,
  input  logic signed [15:0] col_b,
  input  logic signed [15:0] col_c,
  input  logic signed [15:0] col_d,
  input  logic signed [15:0] row_a,
  input  logic signed [15:0] row_b,
  input  logic signed [15:0] row_c,
  input  logic signed [15:0] row_d,
  input  logic [23:0]        palette_color,
  output logic               head_valid,
  output cnps_pkg::item_t    head,
  input  logic               pop_req
);

  localparam int QD  = cnps_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  cnps_pkg::item_t q_mem [QD];
  logic [QAW-1:0]  wptr, rptr;
  logic [QCW-1:0]  count;
  logic            push, pop;
  cnps_pkg::item_t in_item;

  // Palette writes beyond the table are marked here so the back drops them.
  always_comb begin
    in_item.kind      = kind;
    in_item.pal_we    = kind && (32'(x) < PALETTE_ENTRIES);
    in_item.x         = x;
    in_item.y         = y;
    in_item.col_a     = col_a;
    in_item.col_b     = col_b;
    in_item.col_c     = col_c;
    in_item.col_d     = col_d;
    in_item.row_a     = row_a;
    in_item.row_b     = row_b;
    in_item.row_c     = row_c;
    in_item.row_d     = row_d;
    in_item.pal_color = palette_color;
  end

  assign in_ready   = enable && (count != QCW'(QD));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign pop        = pop_req && head_valid;
  assign head       = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

/* hdl/cnps_back.sv */
`timescale 1ns / 1ps
module cnps_back #(
  parameter int PALETTE_ENTRIES = cnps_pkg::PALETTE_ENTRIES_DEF,
  parameter int GRAIN_EDGE      = cnps_pkg::GRAIN_EDGE_DEF,
  parameter int FAW             = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cnps_pkg::item_t head,
  output logic            pop_req,
  input  logic            fill_we,
  input  logic [FAW-1:0]  fill_addr,
  input  logic [7:0]      fill_grain,
  input  logic [16:0]     fill_fine,
  input  logic [16:0]     fill_coarse,
  input  logic [7:0]      tint_red,
  input  logic [7:0]      tint_green,
  input  logic [7:0]      tint_blue,
  input  logic [11:0]     color_offset,
  input  logic [26:0]     diag_scale,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [23:0]     pixel_color
);

  localparam int PW  = $clog2(PALETTE_ENTRIES);
  localparam int GN  = GRAIN_EDGE * GRAIN_EDGE;
  localparam int GW  = $clog2(GN);
  localparam int RW  = $clog2(GRAIN_EDGE);
  localparam int RE  = 4096 / GRAIN_EDGE;
  localparam int RP  = (1 << 25) / PALETTE_ENTRIES;

  function automatic logic [7:0] add_channel(input logic [7:0] tint, input logic [7:0] col,
                                             input logic [7:0] bright);
    logic [15:0] prod;
    logic [8:0]  s;
    prod = 16'(col) * 16'(bright);
    s    = 9'(tint) + 9'(prod[15:8]);
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  logic en;
  assign en      = !out_valid || out_ready;
  assign pop_req = en;

  // Stage 1: the four cosine products, grain tile quotients, diagonal term.
  logic               s1_valid, s1_kind, s1_pwe;
  logic [11:0]        s1_x, s1_y, s1_qx, s1_qy;
  logic [23:0]        s1_pcolor, s1_dterm;
  logic signed [31:0] s1_p1, s1_p2, s1_p3, s1_p4;
  logic [23:0]        qx_prod, qy_prod;
  logic [39:0]        d_prod;

  always_comb begin
    qx_prod = 24'(head.x) * 24'(RE);
    qy_prod = 24'(head.y) * 24'(RE);
    d_prod  = 40'(13'(head.x) + 13'(head.y)) * 40'(diag_scale);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind   <= head.kind;
      s1_pwe    <= head.pal_we;
      s1_x      <= head.x;
      s1_y      <= head.y;
      s1_pcolor <= head.pal_color;
      s1_p1     <= head.col_a * head.row_a;
      s1_p2     <= head.col_b * head.row_b;
      s1_p3     <= head.col_c * head.row_c;
      s1_p4     <= head.col_d * head.row_d;
      s1_qx     <= qx_prod[23:12];
      s1_qy     <= qy_prod[23:12];
      s1_dterm  <= d_prod[39:16];
    end
  end

  // Stage 2: nodal magnitudes to table indexes, grain row and column.
  logic               s2_valid, s2_kind, s2_pwe;
  logic [11:0]        s2_x;
  logic [23:0]        s2_pcolor, s2_dterm;
  logic [9:0]         s2_i1, s2_i2;
  logic [RW-1:0]      s2_rx, s2_ry;
  logic signed [32:0] f1, f2;
  logic [31:0]        m1, m2;
  logic [40:0]        t1, t2;
  logic [9:0]         i1, i2;
  logic [11:0]        rx_raw, ry_raw, rx_fix, ry_fix;

  always_comb begin
    f1 = 33'(s1_p1) - 33'(s1_p2);
    f2 = 33'(s1_p3) - 33'(s1_p4);
    m1 = f1[32] ? 32'(-f1) : 32'(f1);
    m2 = f2[32] ? 32'(-f2) : 32'(f2);
    t1 = (41'(m1) << 9) - 41'(m1);
    t2 = (41'(m2) << 9) - 41'(m2);
    i1 = (t1[40:28] > 13'(cnps_pkg::IDX_MAX)) ? 10'(cnps_pkg::IDX_MAX) : t1[37:28];
    i2 = (t2[40:28] > 13'(cnps_pkg::IDX_MAX)) ? 10'(cnps_pkg::IDX_MAX) : t2[37:28];
    rx_raw = s1_x - 12'(s1_qx * GRAIN_EDGE);
    ry_raw = s1_y - 12'(s1_qy * GRAIN_EDGE);
    rx_fix = (rx_raw >= 12'(GRAIN_EDGE)) ? rx_raw - 12'(GRAIN_EDGE) : rx_raw;
    ry_fix = (ry_raw >= 12'(GRAIN_EDGE)) ? ry_raw - 12'(GRAIN_EDGE) : ry_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind   <= s1_kind;
      s2_pwe    <= s1_pwe;
      s2_x      <= s1_x;
      s2_pcolor <= s1_pcolor;
      s2_dterm  <= s1_dterm;
      s2_i1     <= i1;
      s2_i2     <= i2;
      s2_rx     <= rx_fix[RW-1:0];
      s2_ry     <= ry_fix[RW-1:0];
    end
  end

  // Stage 3: decay tables read; grain address formed.
  logic          s3_valid, s3_kind, s3_pwe;
  logic [11:0]   s3_x;
  logic [23:0]   s3_pcolor, s3_dterm;
  logic [GW-1:0] s3_gaddr;
  logic [16:0]   fine_q, coarse_q;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind   <= s2_kind;
      s3_pwe    <= s2_pwe;
      s3_x      <= s2_x;
      s3_pcolor <= s2_pcolor;
      s3_dterm  <= s2_dterm;
      s3_gaddr  <= GW'(32'(s2_ry) * GRAIN_EDGE + 32'(s2_rx));
    end
  end

  // Stage 4: grain read; coarse term weighted by 0.55.
  logic        s4_valid, s4_kind, s4_pwe;
  logic [11:0] s4_x;
  logic [23:0] s4_pcolor, s4_dterm;
  logic [16:0] s4_fine, s4_w;
  logic [7:0]  grain_q;
  logic [32:0] w_prod;

  assign w_prod = 33'(coarse_q) * 33'(cnps_pkg::WEIGHT_Q16) + 33'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_kind   <= s3_kind;
      s4_pwe    <= s3_pwe;
      s4_x      <= s3_x;
      s4_pcolor <= s3_pcolor;
      s4_dterm  <= s3_dterm;
      s4_fine   <= fine_q;
      s4_w      <= w_prod[32:16];
    end
  end

  // Stage 5: combined intensity, clipped at 1.0.
  logic        s5_valid, s5_kind, s5_pwe;
  logic [11:0] s5_x;
  logic [23:0] s5_pcolor, s5_dterm;
  logic [16:0] s5_v;
  logic [7:0]  s5_grain;
  logic [17:0] v_sum;

  assign v_sum = 18'(s4_fine) + 18'(s4_w);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_kind   <= s4_kind;
      s5_pwe    <= s4_pwe;
      s5_x      <= s4_x;
      s5_pcolor <= s4_pcolor;
      s5_dterm  <= s4_dterm;
      s5_grain  <= grain_q;
      s5_v      <= (v_sum > 18'(cnps_pkg::V_ONE)) ? 17'(cnps_pkg::V_ONE) : v_sum[16:0];
    end
  end

  // Stage 6: brightness and the unreduced palette position.
  logic        s6_valid, s6_kind, s6_pwe;
  logic [11:0] s6_x;
  logic [23:0] s6_pcolor;
  logic [7:0]  s6_bright;
  logic [24:0] s6_sum;
  logic [24:0] b_prod;
  logic [29:0] span_prod;

  always_comb begin
    b_prod    = 25'(s5_v) * 25'(s5_grain);
    span_prod = 30'(s5_v) * 30'(cnps_pkg::PAL_SPAN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_kind   <= s5_kind;
      s6_pwe    <= s5_pwe;
      s6_x      <= s5_x;
      s6_pcolor <= s5_pcolor;
      s6_bright <= b_prod[23:16];
      s6_sum    <= 25'(color_offset) + 25'(span_prod[29:16]) + 25'(s5_dterm);
    end
  end

  // Stage 7: quotient by the palette size through its reciprocal; it may
  // come out one short, which stage 8 corrects.
  logic        s7_valid, s7_kind, s7_pwe;
  logic [11:0] s7_x;
  logic [23:0] s7_pcolor;
  logic [7:0]  s7_bright;
  logic [24:0] s7_sum, s7_q;
  logic [49:0] q_prod;

  assign q_prod = 50'(s6_sum) * 50'(RP);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_kind   <= s6_kind;
      s7_pwe    <= s6_pwe;
      s7_x      <= s6_x;
      s7_pcolor <= s6_pcolor;
      s7_bright <= s6_bright;
      s7_sum    <= s6_sum;
      s7_q      <= q_prod[49:25];
    end
  end

  // Stage 8: palette index; palette writes land in the table here, in order.
  logic          s8_valid, s8_kind, s8_pwe;
  logic [11:0]   s8_x;
  logic [23:0]   s8_pcolor;
  logic [7:0]    s8_bright;
  logic [PW-1:0] s8_pidx;
  logic [37:0]   qp_prod;
  logic [24:0]   r_raw, r_fix;

  always_comb begin
    qp_prod = 38'(s7_q) * 38'(PALETTE_ENTRIES);
    r_raw   = s7_sum - qp_prod[24:0];
    r_fix   = (r_raw >= 25'(PALETTE_ENTRIES)) ? r_raw - 25'(PALETTE_ENTRIES) : r_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_kind   <= s7_kind;
      s8_pwe    <= s7_pwe;
      s8_x      <= s7_x;
      s8_pcolor <= s7_pcolor;
      s8_bright <= s7_bright;
      s8_pidx   <= r_fix[PW-1:0];
    end
  end

  // Stage 9: palette data; the output register follows.
  logic        s9_valid, s9_kind;
  logic [7:0]  s9_bright;
  logic [23:0] pal_q;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_kind   <= s8_kind;
      s9_bright <= s8_bright;
      pixel_color <= {add_channel(tint_red, pal_q[23:16], s9_bright),
                      add_channel(tint_green, pal_q[15:8], s9_bright),
                      add_channel(tint_blue, pal_q[7:0], s9_bright)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      s9_valid  <= s8_valid;
      out_valid <= s9_valid && !s9_kind;
    end
  end

  cnps_ram #(.WIDTH(17), .DEPTH(cnps_pkg::DECAY_DEPTH)) u_fine (
    .clk   (clk),
    .we    (fill_we && (32'(fill_addr) < cnps_pkg::DECAY_DEPTH)),
    .waddr (fill_addr[cnps_pkg::DECAY_AW-1:0]),
    .wdata (fill_fine),
    .re    (en),
    .raddr (s2_i1),
    .rdata (fine_q)
  );

  cnps_ram #(.WIDTH(17), .DEPTH(cnps_pkg::DECAY_DEPTH)) u_coarse (
    .clk   (clk),
    .we    (fill_we && (32'(fill_addr) < cnps_pkg::DECAY_DEPTH)),
    .waddr (fill_addr[cnps_pkg::DECAY_AW-1:0]),
    .wdata (fill_coarse),
    .re    (en),
    .raddr (s2_i2),
    .rdata (coarse_q)
  );

  cnps_ram #(.WIDTH(8), .DEPTH(GN)) u_grain (
    .clk   (clk),
    .we    (fill_we && (32'(fill_addr) < GN)),
    .waddr (fill_addr[GW-1:0]),
    .wdata (fill_grain),
    .re    (en),
    .raddr (s3_gaddr),
    .rdata (grain_q)
  );

  cnps_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (en && s8_valid && s8_kind && s8_pwe),
    .waddr (s8_x[PW-1:0]),
    .wdata (s8_pcolor),
    .re    (en),
    .raddr (s8_pidx),
    .rdata (pal_q)
  );

endmodule

/* hdl/cnps_checker.sv */
`timescale 1ns / 1ps
module cnps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_color
);

  // Reset starts the table sweep and empties the pipeline.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("in_ready or out_valid high right after reset");

  // Outside reset the queue only closes after taking a word.
  a_ready_falls: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready fell without a word accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color))
    else $error("stalled output word changed");

endmodule

bind chladni_nodal_pixel_shader cnps_checker u_cnps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_color (pixel_color)
);

/* tb/sv/chladni_nodal_pixel_shader_checker.sv */
`timescale 1ns / 1ps
module chladni_nodal_pixel_shader_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               kind,
  input  logic [11:0]        x,
  input  logic [11:0]        y,
  input  logic signed [15:0] col_a,
  input  logic signed [15:0] col_b,
  input  logic signed [15:0] col_c,
  input  logic signed [15:0] col_d,
  input  logic signed [15:0] row_a,
  input  logic signed [15:0] row_b,
  input  logic signed [15:0] row_c,
  input  logic signed [15:0] row_d,
  input  logic [23:0]        palette_color,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [23:0]        pixel_color,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [26:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 pixels_checked,
  output int                 palette_writes
);

  localparam int PAL_N = cnps_pkg::PALETTE_ENTRIES_DEF;
  localparam int EDGE  = cnps_pkg::GRAIN_EDGE_DEF;
  localparam int DD    = cnps_pkg::DECAY_DEPTH;

  logic [16:0] fine_decay [DD];
  logic [16:0] coarse_decay [DD];
  logic [7:0]  grain [EDGE * EDGE];
  logic [23:0] palette_mirror [PAL_N];
  logic [7:0]  tint_r, tint_g, tint_b;
  logic [11:0] offset_reg;
  logic [26:0] diag_reg;
  logic [23:0] expected_colors [$];

  // Decay ratio exp(-k/511) in Q2.30 from a truncated ten-term series.
  function automatic longint decay_ratio(input longint k);
    longint term;
    longint acc;
    term = longint'(1) << 30;
    acc  = term;
    for (int n = 1; n <= 10; n++) begin
      term = (term * k) / (longint'(511) * n);
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  function automatic int nodal_idx(input logic signed [15:0] c1, r1, c2, r2);
    longint f;
    longint ix;
    f = longint'(c1) * longint'(r1) - longint'(c2) * longint'(r2);
    if (f < 0) f = -f;
    ix = (f * 511) >>> 28;
    return (ix > cnps_pkg::IDX_MAX) ? cnps_pkg::IDX_MAX : int'(ix);
  endfunction

  function automatic logic [7:0] lit_channel(input logic [7:0] tint, col, bright);
    int s;
    s = int'(tint) + ((int'(col) * int'(bright)) >> 8);
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic logic [23:0] shade_pixel(
    input logic [11:0] px, py,
    input logic signed [15:0] ca, cb, cc, cd, ra, rb, rc, rd
  );
    longint w;
    longint v;
    longint bright;
    longint pidx;
    logic [23:0] c;
    w = (longint'(cnps_pkg::WEIGHT_Q16) * coarse_decay[nodal_idx(cc, rc, cd, rd)] + 32768)
        >>> 16;
    v = fine_decay[nodal_idx(ca, ra, cb, rb)] + w;
    if (v > cnps_pkg::V_ONE) v = cnps_pkg::V_ONE;
    bright = (v * grain[{py[6:0], px[6:0]}]) >>> 16;
    pidx = longint'(offset_reg) + ((v * cnps_pkg::PAL_SPAN) >>> 16)
         + ((longint'(px + 0) + longint'(py)) * longint'(diag_reg) >>> 16);
    c = palette_mirror[pidx % PAL_N];
    return {lit_channel(tint_r, c[23:16], bright[7:0]),
            lit_channel(tint_g, c[15:8], bright[7:0]),
            lit_channel(tint_b, c[7:0], bright[7:0])};
  endfunction

  initial begin
    logic [31:0] s;
    longint b;
    longint p;
    b = decay_ratio(cnps_pkg::DECAY_K_FINE);
    p = longint'(1) << 30;
    for (int i = 0; i < DD; i++) begin
      fine_decay[i] = 17'((p + (1 << 13)) >>> 14);
      p = (p * b + (longint'(1) << 29)) >>> 30;
    end
    b = decay_ratio(cnps_pkg::DECAY_K_COARSE);
    p = longint'(1) << 30;
    for (int i = 0; i < DD; i++) begin
      coarse_decay[i] = 17'((p + (1 << 13)) >>> 14);
      p = (p * b + (longint'(1) << 29)) >>> 30;
    end
    s = cnps_pkg::GRAIN_SEED;
    for (int i = 0; i < EDGE * EDGE; i++) begin
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      grain[i] = 8'(cnps_pkg::GRAIN_BASE + ((s >> 9) & cnps_pkg::GRAIN_MASK));
    end
    fail_count = 0;
    pending = 0;
    pixels_checked = 0;
    palette_writes = 0;
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      tint_r = '0;
      tint_g = '0;
      tint_b = '0;
      offset_reg = '0;
      diag_reg = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cnps_pkg::CFG_TINT_RED:     tint_r = cfg_data[7:0];
          cnps_pkg::CFG_TINT_GREEN:   tint_g = cfg_data[7:0];
          cnps_pkg::CFG_TINT_BLUE:    tint_b = cfg_data[7:0];
          cnps_pkg::CFG_COLOR_OFFSET: offset_reg = cfg_data[11:0];
          cnps_pkg::CFG_DIAG_SCALE:   diag_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, actual %06h",
                   $time, pixel_color);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          pixels_checked++;
          if (pixel_color !== want) begin
            $display("%0t: pixel_color mismatch, expected %06h, actual %06h",
                     $time, want, pixel_color);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (kind) begin
          if (x < PAL_N) begin
            palette_mirror[x] = palette_color;
            palette_writes++;
          end
        end else begin
          expected_colors.push_back(shade_pixel(x, y, col_a, col_b, col_c, col_d,
                                                row_a, row_b, row_c, row_d));
        end
      end
      pending = expected_colors.size();
    end
  end

endmodule

/* tb/sv/chladni_nodal_pixel_shader_tb.sv */
`timescale 1ns / 1ps
module chladni_nodal_pixel_shader_tb;

  // Allow for the table generation pass after reset plus long stalls.
  localparam int WATCHDOG_LIMIT = 60000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic [11:0]        x = '0;
  logic [11:0]        y = '0;
  logic signed [15:0] col_a = '0, col_b = '0, col_c = '0, col_d = '0;
  logic signed [15:0] row_a = '0, row_b = '0, row_c = '0, row_d = '0;
  logic [23:0]        palette_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [23:0]        pixel_color;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [26:0]        cfg_data = '0;

  int fail_count, pending, pixels_checked, palette_writes;
  int idle_cycles = 0;
  int settings_used = 0;
  // Idle mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  int idle_mode = 0;
  int hold_request = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chladni_nodal_pixel_shader u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .x(x), .y(y),
    .col_a(col_a), .col_b(col_b), .col_c(col_c), .col_d(col_d),
    .row_a(row_a), .row_b(row_b), .row_c(row_c), .row_d(row_d),
    .palette_color(palette_color), .out_valid(out_valid), .out_ready(out_ready),
    .pixel_color(pixel_color), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  chladni_nodal_pixel_shader_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .x(x), .y(y),
    .col_a(col_a), .col_b(col_b), .col_c(col_c), .col_d(col_d),
    .row_a(row_a), .row_b(row_b), .row_c(row_c), .row_d(row_d),
    .palette_color(palette_color), .out_valid(out_valid), .out_ready(out_ready),
    .pixel_color(pixel_color), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending),
    .pixels_checked(pixels_checked), .palette_writes(palette_writes)
  );

  // The watchdog restarts whenever a word moves on either channel. A run
  // that stops moving words for too long is declared broken.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t with %0d words pending", $time, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls according to the idle mode. When a hold is requested
  // it keeps out_ready low for a long stretch, counted here, so that the
  // queue fills and the block must drop in_ready.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_mode == 2) begin
        out_ready <= ($urandom_range(99) >= 87);
      end else if (idle_mode == 3) begin
        out_ready <= ($urandom_range(99) >= 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one word and returns at the edge where it is accepted. The valid
  // line only drops when the sender takes a gap, never in the same step it
  // is raised again.
  task automatic send_word(input logic k, input logic [11:0] px, py,
                           input logic signed [15:0] ca, cb, cc, cd,
                           input logic signed [15:0] ra, rb, rc, rd,
                           input logic [23:0] pc);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 87 : (idle_mode == 3) ? 7 : 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    x <= px;
    y <= py;
    col_a <= ca; col_b <= cb; col_c <= cc; col_d <= cd;
    row_a <= ra; row_b <= rb; row_c <= rc; row_d <= rd;
    palette_color <= pc;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pixel(input logic [11:0] px, py,
                            input logic signed [15:0] ca, cb, cc, cd,
                            input logic signed [15:0] ra, rb, rc, rd);
    send_word(1'b0, px, py, ca, cb, cc, cd, ra, rb, rc, rd, 24'($urandom));
  endtask

  // Cosines are mostly in the legal Q1.14 range, with some extremes and
  // some raw 16-bit values, including the out-of-range most negative code.
  function automatic logic signed [15:0] pick_cosine();
    int sel;
    sel = $urandom_range(99);
    if (sel < 78) return 16'($urandom_range(32768) - 16384);
    if (sel < 90) begin
      case ($urandom_range(3))
        0: return -16'sd16384;
        1: return 16'sd16384;
        2: return 16'sd0;
        default: return 16'h8000;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic send_random_word();
    // Some palette writes land past the end of the palette and are dropped.
    if ($urandom_range(99) < 12) begin
      send_word(1'b1, ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(1023)),
                12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
    end else begin
      send_pixel(12'($urandom), 12'($urandom), pick_cosine(), pick_cosine(), pick_cosine(),
                 pick_cosine(), pick_cosine(), pick_cosine(), pick_cosine(), pick_cosine());
    end
  endtask

  // Waits until every expected pixel has come back, then lets the pipeline
  // settle so that a trailing palette write has also landed.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cnps_pkg::cfg_reg_e idx, input logic [26:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Setting 0 is the reset value, 1 the top of each documented range, 2 junk
  // above the narrow registers with green tint and drift all ones, others random.
  task automatic load_setting(input int which);
    logic [26:0] tr, tg, tb, off, dg;
    case (which)
      0: begin
        tr = '0; tg = '0; tb = '0; off = '0; dg = '0;
      end
      1: begin
        tr = 27'd255; tg = 27'd255; tb = 27'd255; off = 27'd4095; dg = 27'd68812800;
      end
      2: begin
        tr = 27'h7FFFF00 | 27'($urandom_range(255));
        tg = 27'h7FFFFFF;
        tb = 27'h5A5A500;
        off = 27'h7FFF000 | 27'($urandom_range(4095));
        dg = 27'h7FFFFFF;
      end
      default: begin
        tr = 27'($urandom_range(255));
        tg = 27'($urandom_range(255));
        tb = 27'($urandom_range(255));
        off = 27'($urandom_range(4095));
        dg = 27'($urandom_range(68812800));
      end
    endcase
    write_reg(cnps_pkg::CFG_TINT_RED, tr);
    write_reg(cnps_pkg::CFG_TINT_GREEN, tg);
    write_reg(cnps_pkg::CFG_TINT_BLUE, tb);
    write_reg(cnps_pkg::CFG_COLOR_OFFSET, off);
    write_reg(cnps_pkg::CFG_DIAG_SCALE, dg);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Registers may be loaded while the tables are still being generated.
    load_setting(0);

    // Every palette entry is written first so that no pixel ever reads an
    // entry that was never written.
    for (int i = 0; i < cnps_pkg::PALETTE_ENTRIES_DEF; i++) begin
      send_word(1'b1, 12'(i), 12'($urandom), '0, '0, '0, '0, '0, '0, '0, '0, 24'($urandom));
    end

    // Directed words: writes past the palette end and at its last entry,
    // zero cosines that saturate the sum, the range extremes, the most
    // negative code, and the coordinate extremes.
    send_word(1'b1, 12'd4095, 12'd0, '0, '0, '0, '0, '0, '0, '0, '0, 24'hFFFFFF);
    send_word(1'b1, 12'd1024, 12'd4095, '0, '0, '0, '0, '0, '0, '0, '0, 24'h123456);
    send_word(1'b1, 12'd1023, 12'd0, '0, '0, '0, '0, '0, '0, '0, '0, 24'hFFFFFF);
    send_word(1'b1, 12'd0, 12'd0, '0, '0, '0, '0, '0, '0, '0, '0, 24'h000000);
    send_pixel(12'd0, 12'd0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_pixel(12'd4095, 12'd4095, '0, '0, '0, '0, '0, '0, '0, '0);
    send_pixel(12'd4095, 12'd0, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
               16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_pixel(12'd0, 12'd4095, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384,
               16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_pixel(12'd127, 12'd127, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
               16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_pixel(12'd128, 12'd128, 16'h8000, '0, 16'h8000, '0, 16'h8000, '0, 16'h8000, '0);
    send_pixel(12'd1, 12'd2, 16'h8000, 16'h8000, '0, 16'h8000, 16'h8000, 16'h8000,
               '0, 16'h8000);
    send_pixel(12'd2048, 12'd1023, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
               16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pixel(12'd3000, 12'd77, 16'd1, '0, '0, 16'd1, 16'd525, '0, '0, 16'd526);
    send_pixel(12'd55, 12'd4000, -16'sd1, -16'sd1, 16'd100, 16'd100,
               16'd9000, -16'sd9000, 16'd3, -16'sd3);

    // Random phases walk through the register settings and idle modes.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      load_setting(ph == 0 ? 1 : ph == 1 ? 2 : ph == 2 ? 0 : 3);
      idle_mode = ph % 4;
      for (int n = 0; n < 66; n++) begin
        // In the first phase the receiver holds off while words keep coming.
        if (ph == 0 && n == 10) hold_request = 300;
        send_random_word();
      end
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Checked %0d shaded pixels with %0d palette writes over %0d register settings,",
             pixels_checked, palette_writes, settings_used);
    $display("with free flow, sender gaps, receiver stalls and a long output hold.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
